>>> sv/integer_text_parser_macros.svh
// ---------------------------------------------------------------------------
// integer_text_parser_macros
// assertion macros shared by the parser modules
// ---------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/itp_pkg.sv
// ---------------------------------------------------------------------------
// itp_pkg
// types and constants of the integer text parser
// ---------------------------------------------------------------------------
package itp_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 16;
    localparam int RADIX_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIX       = 2'd1;

    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] RESET_RADIX = BASE_DEC;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [RADIX_W-1:0] LETTER_BASE = 6'd10;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [OFFSET_BITS-1:0] end_offset;
    } t_out;

    typedef struct packed {
        logic               blank;
        logic               alnum;
        logic [RADIX_W-1:0] dval;
    } t_char_class;

endpackage

>>> sv/integer_text_parser.sv
// ---------------------------------------------------------------------------
// integer_text_parser
// string-to-integer parser fed one character per transfer
// ---------------------------------------------------------------------------
// usage
//   input channel: one character and a start flag per transfer; the flag
//   marks the first character of a new string and samples signed_mode and
//   radix. a string yields one result when its first non-digit arrives;
//   characters after that are dropped until the next start.
//   output channel: parsed value (two's complement) and end offset.
//   configuration: write enable, index and data; write only while idle.
// timing
//   one character per cycle sustained while no result waits. a character is
//   registered on entry and stepped through the parser from the input
//   register; its result, if any, is registered in the output register.
//   the per-character path is one multiply-accumulate by the base.
// reset and stall
//   synchronous reset clears both stages, the parse state and sets the
//   registers to signed mode, base 10. while a result waits the parser
//   holds; the input register still takes one more character.
// ---------------------------------------------------------------------------
`include "integer_text_parser_macros.svh"

module integer_text_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  itp_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output itp_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [itp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic                            r_in_valid;
    itp_pkg::t_in                    r_in;
    logic                            r_out_valid;
    itp_pkg::t_out                   r_out;
    logic                            r_signed_mode;
    logic [itp_pkg::RADIX_W-1:0]     r_radix;

    logic                            w_step;
    logic                            w_emit;
    itp_pkg::t_out                   w_result;
    itp_pkg::t_char_class            w_class;

    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    itp_classify u_classify (
        .i_ch    (r_in.ch),
        .o_class (w_class)
    );

    itp_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_ch          (r_in.ch),
        .i_start       (r_in.start_req),
        .i_class       (w_class),
        .i_signed_mode (r_signed_mode),
        .i_radix       (r_radix),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_radix       <= itp_pkg::RESET_RADIX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                itp_pkg::CFG_IDX_SIGNED_MODE: r_signed_mode <= i_cfg_wdata[0];
                itp_pkg::CFG_IDX_RADIX:       r_radix <= i_cfg_wdata[itp_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    `ITP_ASSERT_NOW(a_no_step_into_stall, o_out_valid && !i_out_ready, !w_step, "parser stepped while result stalled")
    `ITP_ASSERT_NEXT(a_step_sets_out, w_step, o_out_valid == $past(w_emit), "result register out of step with parser")
    `ITP_ASSERT_NOW(a_ready_when_empty, !r_in_valid, o_in_ready, "input register empty but not ready")

endmodule

>>> sv/itp_classify.sv
// ---------------------------------------------------------------------------
// itp_classify
// character classifier: whitespace flag, alphanumeric flag and digit value of one byte
// ---------------------------------------------------------------------------
module itp_classify (
    input  logic [7:0]          i_ch,
    output itp_pkg::t_char_class o_class
);

    always_comb begin
        o_class.blank = (i_ch == itp_pkg::CH_SPACE) ||
                        (i_ch >= itp_pkg::CH_TAB && i_ch <= itp_pkg::CH_CR);
        o_class.alnum = 1'b1;
        o_class.dval  = '0;
        if (i_ch >= itp_pkg::CH_0 && i_ch <= itp_pkg::CH_9) begin
            o_class.dval = itp_pkg::RADIX_W'(i_ch - itp_pkg::CH_0);
        end else if (i_ch >= itp_pkg::CH_LA && i_ch <= itp_pkg::CH_LZ) begin
            o_class.dval = itp_pkg::RADIX_W'(i_ch - itp_pkg::CH_LA) + itp_pkg::LETTER_BASE;
        end else if (i_ch >= itp_pkg::CH_UA && i_ch <= itp_pkg::CH_UZ) begin
            o_class.dval = itp_pkg::RADIX_W'(i_ch - itp_pkg::CH_UA) + itp_pkg::LETTER_BASE;
        end else begin
            o_class.alnum = 1'b0;
        end
    end

endmodule

>>> sv/itp_parse_core.sv
// ---------------------------------------------------------------------------
// itp_parse_core
// parse state and one-character step: whitespace, signs, prefix, multiply-accumulate
// ---------------------------------------------------------------------------
`include "integer_text_parser_macros.svh"

module itp_parse_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_ch,
    input  logic                         i_start,
    input  itp_pkg::t_char_class         i_class,
    input  logic                         i_signed_mode,
    input  logic [itp_pkg::RADIX_W-1:0]  i_radix,
    output logic                         o_emit,
    output itp_pkg::t_out                o_result
);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_WS1,
        PH_WS2,
        PH_PREFIX,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } t_phase;

    localparam logic [itp_pkg::OFFSET_BITS-1:0] OFFSET_MAX = '1;

    t_phase                              r_phase, n_phase;
    logic                                r_minus, n_minus;
    logic [itp_pkg::VALUE_BITS-1:0]      r_accum, n_accum;
    logic [itp_pkg::RADIX_W-1:0]         r_base, n_base;
    logic [itp_pkg::OFFSET_BITS-1:0]     r_consumed, n_consumed;
    logic [itp_pkg::VALUE_BITS+itp_pkg::RADIX_W-1:0] w_prod;
    logic                                w_go;

    function automatic logic [itp_pkg::OFFSET_BITS-1:0] f_take(
        input logic [itp_pkg::OFFSET_BITS-1:0] cnt
    );
        return (cnt == OFFSET_MAX) ? cnt : cnt + itp_pkg::OFFSET_BITS'(1);
    endfunction

    function automatic logic f_ok(
        input itp_pkg::t_char_class cc,
        input logic [itp_pkg::RADIX_W-1:0] base
    );
        return cc.alnum && (cc.dval < base);
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_minus    = r_minus;
        n_accum    = r_accum;
        n_base     = r_base;
        n_consumed = r_consumed;
        w_prod     = '0;
        w_go       = 1'b1;
        o_emit     = 1'b0;
        o_result.end_offset = '0;

        if (i_start) begin
            n_minus    = 1'b0;
            n_accum    = '0;
            n_consumed = '0;
            n_base     = i_radix;
            n_phase    = i_signed_mode ? PH_WS1 : PH_WS2;
        end

        // leading whitespace and sign
        if (n_phase == PH_WS1) begin
            if (i_class.blank) begin
                n_consumed = f_take(n_consumed);
                w_go       = 1'b0;
            end else if (i_ch == itp_pkg::CH_MINUS || i_ch == itp_pkg::CH_PLUS) begin
                n_minus    = (i_ch == itp_pkg::CH_MINUS);
                n_consumed = f_take(n_consumed);
                n_phase    = PH_WS2;
                w_go       = 1'b0;
            end else begin
                n_phase = PH_WS2;
            end
        end

        if (w_go && n_phase == PH_WS2) begin
            if (i_class.blank) begin
                n_consumed = f_take(n_consumed);
                w_go       = 1'b0;
            end else if (i_ch == itp_pkg::CH_PLUS) begin
                n_consumed = f_take(n_consumed);
                n_phase    = PH_PREFIX;
                w_go       = 1'b0;
            end else begin
                n_phase = PH_PREFIX;
            end
        end

        // first significant character
        if (w_go && n_phase == PH_PREFIX) begin
            w_go = 1'b0;
            if (i_ch == itp_pkg::CH_0 &&
                (n_base == '0 || n_base == itp_pkg::BASE_HEX)) begin
                n_accum    = '0;
                n_consumed = f_take(n_consumed);
                n_phase    = PH_ZERO;
            end else begin
                if (n_base == '0) begin
                    n_base = itp_pkg::BASE_DEC;
                end
                if (!f_ok(i_class, n_base)) begin
                    n_accum             = '0;
                    o_emit              = 1'b1;
                    o_result.end_offset = '0;
                    n_phase             = PH_DONE;
                end else begin
                    n_accum    = itp_pkg::VALUE_BITS'(i_class.dval);
                    n_consumed = f_take(n_consumed);
                    n_phase    = PH_DIGITS;
                end
            end
        end

        // after a leading zero
        if (w_go && n_phase == PH_ZERO) begin
            if (i_ch == itp_pkg::CH_LX || i_ch == itp_pkg::CH_UX) begin
                n_base     = itp_pkg::BASE_HEX;
                n_consumed = f_take(n_consumed);
                n_phase    = PH_HEXPFX;
                w_go       = 1'b0;
            end else begin
                if (n_base == '0) begin
                    n_base = itp_pkg::BASE_OCT;
                end
                n_phase = PH_DIGITS;
            end
        end

        // bare hex prefix stops just after the zero
        if (w_go && n_phase == PH_HEXPFX) begin
            if (!f_ok(i_class, n_base)) begin
                o_emit              = 1'b1;
                o_result.end_offset = (n_consumed == OFFSET_MAX) ? n_consumed :
                                      n_consumed - itp_pkg::OFFSET_BITS'(1);
                n_phase             = PH_DONE;
                w_go                = 1'b0;
            end else begin
                n_phase = PH_DIGITS;
            end
        end

        if (w_go && n_phase == PH_DIGITS) begin
            if (!f_ok(i_class, n_base)) begin
                o_emit              = 1'b1;
                o_result.end_offset = n_consumed;
                n_phase             = PH_DONE;
            end else begin
                w_prod     = n_accum * n_base;
                n_accum    = w_prod[itp_pkg::VALUE_BITS-1:0] +
                             itp_pkg::VALUE_BITS'(i_class.dval);
                n_consumed = f_take(n_consumed);
            end
        end

        o_result.value = n_minus ? (itp_pkg::VALUE_BITS'(0) - n_accum) : n_accum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DONE;
            r_minus    <= 1'b0;
            r_accum    <= '0;
            r_base     <= '0;
            r_consumed <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_minus    <= n_minus;
            r_accum    <= n_accum;
            r_base     <= n_base;
            r_consumed <= n_consumed;
        end
    end

    `ITP_ASSERT_NOW(a_emit_needs_parse, i_step && o_emit, i_start || r_phase != PH_DONE, "result without an open parse")
    `ITP_ASSERT_NEXT(a_emit_closes, i_step && o_emit, r_phase == PH_DONE, "parse left open after its result")

endmodule
